/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each one is clocked on clk and is
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be seen at a rising edge.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/fppid_pkg.sv */
package fppid_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int DT_W          = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int SUM_W         = DATA_W + 2;

    localparam logic [DT_W-1:0]          DT_RESET      = 31'd65536;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_DT      = 3'd3,
        REG_OUT_MAX = 3'd4,
        REG_OUT_MIN = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_DT,
        ST_KP,
        ST_KI,
        ST_I_TERM,
        ST_WAIT_DIV,
        ST_KD,
        ST_SUM,
        ST_CLAMP
    } state_t;

endpackage

/* rtl/core/fixed_point_pid_controller_top.sv */
// Q16.16 PID controller with a shared multiplier and a bit-serial divider.
// Input channel: setpoint and measured, with in_valid and in_stall. A request
// is taken when in_valid is high and in_stall is low; in_stall is low only
// while the sequencer is idle.
// Output channel: drive, with out_valid and out_stall. One result is given
// for every input request and is held in an output register until taken.
// The divider resolves one quotient bit a cycle over 32 + FRAC_BITS bits;
// the four products share one multiplier, and the first three overlap
// with the division. A new request is taken only when the sequencer is
// back in idle, after the result has been loaded into the output register.
// Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
// cycle. The user must make writes while the block is idle; it is not enforced.
// Reset clears the integral and the previous error and loads the default
// gains, period and clamp limits. A stalled result stays in the output
// register; the sequencer waits at the clamp step while that register is
// still full and out_stall is high, so nothing is lost.
`include "assert_macros.svh"

module fixed_point_pid_controller_top
#(
    parameter int FRAC_BITS = fppid_pkg::FRAC_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [fppid_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fppid_pkg::DATA_W-1:0]            cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [fppid_pkg::DATA_W-1:0]     setpoint,
    input  logic signed [fppid_pkg::DATA_W-1:0]     measured,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [fppid_pkg::DATA_W-1:0]     drive
);

    localparam int DATA_W = fppid_pkg::DATA_W;
    localparam int DT_W   = fppid_pkg::DT_W;
    localparam int SUM_W  = fppid_pkg::SUM_W;

    fppid_pkg::state_t state_reg;
    fppid_pkg::state_t state_next;

    logic signed [DATA_W-1:0] kp_reg;
    logic signed [DATA_W-1:0] ki_reg;
    logic signed [DATA_W-1:0] kd_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic signed [DATA_W-1:0] out_min_reg;

    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] prev_err_reg;
    logic signed [DATA_W-1:0] integral_reg;
    logic signed [DATA_W-1:0] p_reg;
    logic signed [DATA_W-1:0] i_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     out_valid_reg;

    logic                       accept;
    logic                       load_out;
    logic signed [DATA_W-1:0]   err_new;
    logic signed [DATA_W-1:0]   err_diff;
    logic                       mul_en;
    logic signed [DATA_W-1:0]   mul_a;
    logic signed [DATA_W-1:0]   mul_b;
    logic signed [2*DATA_W-1:0] product;
    logic signed [DATA_W-1:0]   mul_q;
    logic                       div_start;
    logic                       div_busy;
    logic [DATA_W-1:0]          div_quot;
    logic signed [SUM_W-1:0]    max_ext;
    logic signed [SUM_W-1:0]    min_ext;
    logic signed [DATA_W-1:0]   clamp_val;
    logic                       clamp_bad;

    assign in_stall = (state_reg != fppid_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign err_new  = setpoint - measured;
    assign err_diff = err_new - prev_err_reg;
    assign load_out = (state_reg == fppid_pkg::ST_CLAMP) && (!out_valid_reg || !out_stall);

    // Product scaled back to Q16.16 and cut to one word.
    assign mul_q = product[FRAC_BITS+DATA_W-1 -: DATA_W];

    fppid_mul u_mul
    (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    fppid_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (err_diff),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fppid_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = fppid_pkg::ST_ERR_DT;
                end
            end
            fppid_pkg::ST_ERR_DT:   state_next = fppid_pkg::ST_KP;
            fppid_pkg::ST_KP:       state_next = fppid_pkg::ST_KI;
            fppid_pkg::ST_KI:       state_next = fppid_pkg::ST_I_TERM;
            fppid_pkg::ST_I_TERM:   state_next = fppid_pkg::ST_WAIT_DIV;
            fppid_pkg::ST_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = fppid_pkg::ST_KD;
                end
            end
            fppid_pkg::ST_KD:       state_next = fppid_pkg::ST_SUM;
            fppid_pkg::ST_SUM:      state_next = fppid_pkg::ST_CLAMP;
            fppid_pkg::ST_CLAMP:
            begin
                if (load_out)
                begin
                    state_next = fppid_pkg::ST_IDLE;
                end
            end
            default:                state_next = fppid_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_en    = 1'b0;
        mul_a     = kp_reg;
        mul_b     = err_reg;
        div_start = 1'b0;
        unique case (state_reg)
            fppid_pkg::ST_IDLE:
            begin
                div_start = accept;
            end
            fppid_pkg::ST_ERR_DT:
            begin
                mul_en = 1'b1;
                mul_a  = err_reg;
                mul_b  = signed'({1'b0, dt_reg});
            end
            fppid_pkg::ST_KP:
            begin
                mul_en = 1'b1;
                mul_a  = kp_reg;
                mul_b  = err_reg;
            end
            fppid_pkg::ST_KI:
            begin
                mul_en = 1'b1;
                mul_a  = ki_reg;
                mul_b  = integral_reg;
            end
            fppid_pkg::ST_KD:
            begin
                mul_en = 1'b1;
                mul_a  = kd_reg;
                mul_b  = signed'(div_quot);
            end
            fppid_pkg::ST_I_TERM,
            fppid_pkg::ST_WAIT_DIV,
            fppid_pkg::ST_SUM,
            fppid_pkg::ST_CLAMP:
            begin
                mul_en = 1'b0;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign max_ext   = {{(SUM_W-DATA_W){out_max_reg[DATA_W-1]}}, out_max_reg};
    assign min_ext   = {{(SUM_W-DATA_W){out_min_reg[DATA_W-1]}}, out_min_reg};
    // The upper bound is tested first, so it wins whenever the sum exceeds it, also when the limits are inverted.
    assign clamp_val = (sum_reg > max_ext) ? out_max_reg :
                       (sum_reg < min_ext) ? out_min_reg : sum_reg[DATA_W-1:0];

    assign clamp_bad = load_out && (out_min_reg <= out_max_reg) &&
                       ((clamp_val > out_max_reg) || (clamp_val < out_min_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fppid_pkg::ST_IDLE;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            dt_reg        <= fppid_pkg::DT_RESET;
            out_max_reg   <= fppid_pkg::OUT_MAX_RESET;
            out_min_reg   <= fppid_pkg::OUT_MIN_RESET;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (fppid_pkg::cfg_reg_t'(cfg_index))
                    fppid_pkg::REG_KP:      kp_reg      <= cfg_data;
                    fppid_pkg::REG_KI:      ki_reg      <= cfg_data;
                    fppid_pkg::REG_KD:      kd_reg      <= cfg_data;
                    fppid_pkg::REG_DT:      dt_reg      <= cfg_data[DT_W-1:0];
                    fppid_pkg::REG_OUT_MAX: out_max_reg <= cfg_data;
                    fppid_pkg::REG_OUT_MIN: out_min_reg <= cfg_data;
                    default:                kp_reg      <= kp_reg;
                endcase
            end

            // The difference for the derivative is formed on the way in, so the
            // new error can be stored at once.
            if (accept)
            begin
                prev_err_reg <= err_new;
            end

            if (state_reg == fppid_pkg::ST_KP)
            begin
                integral_reg <= integral_reg + mul_q;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= err_new;
        end
        if (state_reg == fppid_pkg::ST_KI)
        begin
            p_reg <= mul_q;
        end
        if (state_reg == fppid_pkg::ST_I_TERM)
        begin
            i_reg <= mul_q;
        end
        if (state_reg == fppid_pkg::ST_SUM)
        begin
            sum_reg <= SUM_W'(p_reg) + SUM_W'(i_reg) + SUM_W'(mul_q);
        end
        if (load_out)
        begin
            drive_reg <= clamp_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    `ASSERT_CLK(a_div_starts, accept |=> div_busy, "divider did not start on a new request")
    `ASSERT_NEVER(a_idle_div_quiet, !in_stall && div_busy, "divider busy while idle")
    `ASSERT_NEVER(a_clamp_bounds, clamp_bad, "drive outside clamp limits")

endmodule

/* rtl/core/fppid_mul.sv */
module fppid_mul
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [fppid_pkg::DATA_W-1:0]    a,
    input  logic signed [fppid_pkg::DATA_W-1:0]    b,
    output logic signed [2*fppid_pkg::DATA_W-1:0]  product
);

    logic signed [2*fppid_pkg::DATA_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= a * b;
        end
    end

    assign product = product_reg;

endmodule

/* rtl/core/fppid_div.sv */
module fppid_div
#(
    parameter int FRAC_BITS = fppid_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [fppid_pkg::DATA_W-1:0]  dividend,
    input  logic [fppid_pkg::DT_W-1:0]           divisor,
    output logic                                 busy,
    output logic [fppid_pkg::DATA_W-1:0]         quotient
);

    localparam int DATA_W = fppid_pkg::DATA_W;
    localparam int DT_W   = fppid_pkg::DT_W;
    localparam int NUM_W  = DATA_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [DT_W-1:0]   rem_reg;
    logic [DT_W-1:0]   rem_next;
    logic [DT_W-1:0]   divisor_reg;
    logic [DATA_W-1:0] quot_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [DATA_W-1:0] magnitude;
    logic [DT_W:0]     rem_shift;
    logic [DT_W:0]     rem_sub;
    logic              fits;

    // The magnitude of the most negative value is still right as an unsigned number.
    assign magnitude = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});
    assign rem_next  = fits ? rem_sub[DT_W-1:0] : rem_shift[DT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    // Only the low word of the quotient is kept; negation modulo 2^32 gives the same word.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg     <= {magnitude, {FRAC_BITS{1'b0}}};
            rem_reg     <= '0;
            quot_reg    <= '0;
            divisor_reg <= divisor;
            neg_reg     <= dividend[DATA_W-1];
            zero_reg    <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[DATA_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? (~quot_reg + 1'b1) : quot_reg);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int DATA_W    = fppid_pkg::DATA_W;
    localparam int DT_W      = fppid_pkg::DT_W;
    localparam int CFG_IDX_W = fppid_pkg::CFG_IDX_W;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 6;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 125;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] S_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN  = 32'sh8000_0000;
    localparam logic [DT_W-1:0]          DT_MAX = 31'h7FFF_FFFF;

    typedef enum int {MIX_TAME, MIX_WILD, MIX_INVERTED} gain_mix_t;
    typedef enum int {SAMPLE_TRACK, SAMPLE_RAW, SAMPLE_EDGE} sample_kind_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sp;
        logic signed [DATA_W-1:0] pv;
    } sample_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [DATA_W-1:0]           cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic signed [DATA_W-1:0]    setpoint  = '0;
    logic signed [DATA_W-1:0]    measured  = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [DATA_W-1:0]    drive;

    fixed_point_pid_controller_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .setpoint  (setpoint),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

    // Controller copy: gains, period, limits and loop state.
    logic signed [DATA_W-1:0] gain_p   = '0;
    logic signed [DATA_W-1:0] gain_i   = '0;
    logic signed [DATA_W-1:0] gain_d   = '0;
    logic [DT_W-1:0]          period   = fppid_pkg::DT_RESET;
    logic signed [DATA_W-1:0] lim_hi   = fppid_pkg::OUT_MAX_RESET;
    logic signed [DATA_W-1:0] lim_lo   = fppid_pkg::OUT_MIN_RESET;
    logic signed [DATA_W-1:0] integ_acc = '0;
    logic signed [DATA_W-1:0] last_err  = '0;

    sample_t                  pending_q[$];
    logic signed [DATA_W-1:0] drive_q[$];
    sample_t                  next_req;
    logic signed [DATA_W-1:0] got_want;

    int  total_pushed  = 0;
    int  results_seen  = 0;
    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  hold_asked    = 0;
    int  hold_granted  = 0;
    int  hold_left     = 0;
    bit  calm          = 1'b0;

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod[47:16];
    endfunction

    function automatic logic signed [DATA_W-1:0] q_div(input logic signed [DATA_W-1:0] a,
                                                      input logic [DT_W-1:0] d);
        longint num;
        longint quo;
        if (d == '0)
            return '0;
        num = longint'(a) <<< 16;
        quo = num / longint'(d);
        return quo[31:0];
    endfunction

    // Advances the loop state by one sample and returns the clamped drive.
    function automatic logic signed [DATA_W-1:0] predict_drive(
        input logic signed [DATA_W-1:0] sp,
        input logic signed [DATA_W-1:0] pv);
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] p_part;
        logic signed [DATA_W-1:0] i_part;
        logic signed [DATA_W-1:0] d_part;
        logic signed [DATA_W-1:0] slope;
        logic signed [DATA_W-1:0] result;
        longint total;
        err       = sp - pv;
        p_part    = q_mul(gain_p, err);
        integ_acc = integ_acc + q_mul(err, signed'({1'b0, period}));
        i_part    = q_mul(gain_i, integ_acc);
        slope     = q_div(err - last_err, period);
        d_part    = q_mul(gain_d, slope);
        total     = longint'(p_part) + longint'(i_part) + longint'(d_part);
        // The upper limit is tested first, which matters when the limits are crossed.
        if (total > longint'(lim_hi))
            result = lim_hi;
        else if (total < longint'(lim_lo))
            result = lim_lo;
        else
            result = total[31:0];
        last_err = err;
        return result;
    endfunction

    task automatic note_fail(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected %h, got %h", what, want, got);
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            setpoint <= '0;
            measured <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                drive_q.push_back(predict_drive(setpoint, measured));
            if (in_valid && in_stall)
            begin
                // Held request stays on the bus unchanged.
            end
            else if (pending_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_req = pending_q.pop_front();
                setpoint <= next_req.sp;
                measured <= next_req.pv;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor and output back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                    note_fail("drive with no request outstanding", '0, drive);
                else
                begin
                    got_want = drive_q.pop_front();
                    if (drive !== got_want)
                        note_fail("drive mismatch", got_want, drive);
                end
                results_seen++;
            end
            if (hold_granted != hold_asked)
            begin
                hold_left    = HOLD_CYCLES;
                hold_granted = hold_asked;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fixed_point_pid_controller_top verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            fppid_pkg::REG_KP:      gain_p = data;
            fppid_pkg::REG_KI:      gain_i = data;
            fppid_pkg::REG_KD:      gain_d = data;
            fppid_pkg::REG_DT:      period = data[DT_W-1:0];
            fppid_pkg::REG_OUT_MAX: lim_hi = data;
            fppid_pkg::REG_OUT_MIN: lim_lo = data;
            default:                ;
        endcase
    endtask

    task automatic load_settings(input logic signed [DATA_W-1:0] kp_v,
                                 input logic signed [DATA_W-1:0] ki_v,
                                 input logic signed [DATA_W-1:0] kd_v,
                                 input logic [DT_W-1:0]          dt_v,
                                 input logic signed [DATA_W-1:0] hi_v,
                                 input logic signed [DATA_W-1:0] lo_v);
        write_reg(fppid_pkg::REG_KP, kp_v);
        write_reg(fppid_pkg::REG_KI, ki_v);
        // The top bit of the period write is unused and is toggled on purpose.
        write_reg(fppid_pkg::REG_DT, {1'($urandom_range(1)), dt_v});
        write_reg(fppid_pkg::REG_KD, kd_v);
        write_reg(fppid_pkg::REG_OUT_MAX, hi_v);
        write_reg(fppid_pkg::REG_OUT_MIN, lo_v);
        write_reg(REG_SPARE6, $urandom);
        write_reg(REG_SPARE7, $urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] near_zero(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic logic signed [DATA_W-1:0] edge_value();
        case ($urandom_range(4))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    task automatic push_sample(input logic signed [DATA_W-1:0] sp,
                               input logic signed [DATA_W-1:0] pv);
        sample_t s;
        s.sp = sp;
        s.pv = pv;
        pending_q.push_back(s);
        total_pushed++;
    endtask

    task automatic push_random(input sample_kind_t kind);
        logic signed [DATA_W-1:0] sp;
        case (kind)
            SAMPLE_TRACK:
            begin
                sp = near_zero(1 << 22);
                push_sample(sp, sp + near_zero(1 << 14));
            end
            SAMPLE_RAW:
                push_sample($urandom, $urandom);
            default:
                push_sample(edge_value(), edge_value());
        endcase
    endtask

    task automatic pick_settings(input gain_mix_t mix);
        logic [DT_W-1:0] dt_v;
        case (mix)
            MIX_TAME:
                load_settings(near_zero(1 << 18), near_zero(1 << 18), near_zero(1 << 18),
                              DT_W'($urandom_range(1 << 17, 1)),
                              int'($urandom_range(1 << 24)), -int'($urandom_range(1 << 24)));
            MIX_WILD:
            begin
                dt_v = DT_W'($urandom);
                if (dt_v == '0)
                    dt_v = DT_W'(1);
                if ($urandom_range(1))
                    load_settings($urandom, $urandom, $urandom, dt_v, S_MAX, S_MIN);
                else
                    load_settings($urandom, $urandom, $urandom, dt_v, $urandom, $urandom);
            end
            default:
                load_settings(near_zero(1 << 18), near_zero(1 << 18), near_zero(1 << 18),
                              DT_W'($urandom_range(1 << 17, 1)),
                              -int'($urandom_range(1 << 20, 1)), int'($urandom_range(1 << 20, 1)));
        endcase
    endtask

    // Waits until every request has been answered and the block is idle again.
    task automatic drain();
        while (results_seen < total_pushed)
            @(posedge clk);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        int r;
        int p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Default settings after reset: zero gains, unit period, full range.
        push_sample(Q_ONE, '0);
        push_sample(S_MAX, S_MIN);
        push_sample(-Q_ONE, Q_ONE);
        drain();

        load_settings(Q_ONE, Q_ONE >>> 1, Q_ONE >>> 2, 31'd65536, S_MAX, S_MIN);
        push_sample('0, '0);
        push_sample(S_MAX, S_MIN);
        push_sample(S_MIN, S_MAX);
        push_sample(S_MAX, S_MAX);
        push_sample(S_MIN, S_MIN);
        push_sample(S_MAX, '0);
        push_sample(S_MIN, '0);
        push_sample(-1, 1);
        push_sample(32'sh1234_5678, 32'sh8765_4321);
        push_sample('0, 32'sh0003_8000);
        drain();

        // Largest gains with the shortest period push every term to its extreme.
        load_settings(S_MAX, S_MIN, S_MAX, 31'd1, S_MAX, S_MIN);
        push_sample(S_MAX, S_MIN);
        push_sample(S_MIN, S_MAX);
        push_sample(Q_ONE, '0);
        push_sample('0, Q_ONE);
        drain();

        // Crossed limits: upper limit below the lower one.
        load_settings(Q_ONE, '0, '0, DT_MAX, -(Q_ONE * 5), Q_ONE * 5);
        push_sample(Q_ONE * 100, '0);
        push_sample(-(Q_ONE * 100), '0);
        push_sample('0, '0);
        push_sample(Q_ONE * 7, Q_ONE * 5);
        drain();

        load_settings(S_MIN, S_MAX, S_MIN, DT_MAX, S_MIN, S_MAX);
        push_sample(S_MAX, S_MIN);
        push_sample(S_MIN, S_MAX);
        push_sample(-1, '0);
        drain();

        for (p = 0; p < RAND_PHASES; p++)
        begin
            pick_settings(gain_mix_t'(p % 3));
            calm = (p == 3);
            for (r = 0; r < PHASE_ITEMS; r++)
            begin
                if ($urandom_range(99) < 70)
                    push_random(SAMPLE_TRACK);
                else if ($urandom_range(99) < 66)
                    push_random(SAMPLE_RAW);
                else
                    push_random(SAMPLE_EDGE);
            end
            // Hold the output side off so that requests back up behind a full block.
            if (p == 5)
                hold_asked++;
            drain();
        end
        calm = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && drive_q.size() == 0)
            $display("fixed_point_pid_controller_top verification clean");
        else
            $display("fixed_point_pid_controller_top verification failed");
        $finish;
    end

endmodule
